### rtl/dtsw_pkg.sv
// dtsw_pkg: shared types and constants for the depth-tested span writer
// used by dtsw_plane_mem and depth_tested_span_writer_core
`timescale 1ns / 1ps
`default_nettype none

package dtsw_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(STORE_SIZE);
	localparam int CLR_CNT_W  = ADDR_W + 1;
	localparam int COLOR_W    = 24;
	localparam int DEPTH_W    = 32;
	localparam int COUNT_W    = 9;
	localparam int COORD_W    = 12;
	localparam int DIM_W      = 9;
	localparam int IDX_W      = 1;

	localparam logic [DEPTH_W-1:0] FAR_DEPTH = 32'h0400_0000;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_POINT = 2'd1,
		MODE_SPAN  = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	// one write port and one read port per cycle, shared by both planes
	typedef struct packed {
		logic [ADDR_W-1:0]  rd_addr;
		logic [ADDR_W-1:0]  wr_addr;
		logic               wr_color_en;
		logic               wr_depth_en;
		logic [COLOR_W-1:0] wr_color;
		logic [DEPTH_W-1:0] wr_depth;
	} mem_req_t;

endpackage

`default_nettype wire

### rtl/dtsw_plane_mem.sv
// dtsw_plane_mem: color plane and depth plane storage, registered read
// depends on dtsw_pkg for widths and the request struct
`timescale 1ns / 1ps
`default_nettype none

module dtsw_plane_mem (
	input  wire logic                        clk,
	input  wire dtsw_pkg::mem_req_t          req,
	output logic [dtsw_pkg::COLOR_W-1:0]     rd_color,
	output logic [dtsw_pkg::DEPTH_W-1:0]     rd_depth
);

	logic [dtsw_pkg::COLOR_W-1:0] color_mem [dtsw_pkg::STORE_SIZE];
	logic [dtsw_pkg::DEPTH_W-1:0] depth_mem [dtsw_pkg::STORE_SIZE];

	always_ff @(posedge clk) begin
		if (req.wr_color_en) begin
			color_mem[req.wr_addr] <= req.wr_color;
		end
		rd_color <= color_mem[req.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (req.wr_depth_en) begin
			depth_mem[req.wr_addr] <= req.wr_depth;
		end
		rd_depth <= depth_mem[req.rd_addr];
	end

endmodule

`default_nettype wire

### rtl/depth_tested_span_writer_core.sv
// depth_tested_span_writer_core: z-buffered frame store, one beat in, one beat out
// a point, read or span passes setup, multiply, launch, a span step per row, drain
// and done, or skips to done if off-frame; a clear sweeps width*height entries
// span rows: one pixel per cycle through the read-compare-write loop on the store
// after reset all 65536 store entries are swept once with s_tready low
// depends on dtsw_pkg and dtsw_plane_mem
`timescale 1ns / 1ps
`default_nettype none

module depth_tested_span_writer_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// fields: x_pos, row_start, row_end, pixel_color, depth_value,
	// clear_colors, clear_depths, zero pad
	input  wire logic [95:0]                   s_tdata,
	// fields: mode
	input  wire logic [1:0]                    s_tuser,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// fields: read_color, read_depth, pixels_written, zero pad
	output logic [71:0]                        m_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic                          cfg_we,
	input  wire logic [dtsw_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [dtsw_pkg::DIM_W-1:0]    cfg_data
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_LAUNCH,
		ST_SPAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [dtsw_pkg::DIM_W-1:0] frame_width_q, frame_height_q;
	logic [dtsw_pkg::DIM_W-1:0] ew, eh;

	// captured item
	dtsw_pkg::mode_t             mode_q;
	logic [dtsw_pkg::COORD_W-1:0] x_q, y0_q, y1_q;
	logic [dtsw_pkg::COLOR_W-1:0] color_q;
	logic [dtsw_pkg::DEPTH_W-1:0] depth_q;
	logic                         clr_c_q, clr_d_q;

	// sequencer
	logic                           boot_q;
	logic                           ok_q;
	logic [7:0]                     lo_q;
	logic [dtsw_pkg::DIM_W-1:0]     rows_q;
	logic [2*dtsw_pkg::DIM_W-1:0]   prod_q;
	logic [dtsw_pkg::ADDR_W-1:0]    addr_q;
	logic [dtsw_pkg::CLR_CNT_W-1:0] clr_cnt_q, clr_n_q;
	logic                           valid_s1;
	logic [dtsw_pkg::ADDR_W-1:0]    addr_s1;
	logic [dtsw_pkg::COUNT_W-1:0]   count_q;
	logic [dtsw_pkg::COLOR_W-1:0]   rc_q;
	logic [dtsw_pkg::DEPTH_W-1:0]   rd_q;

	// output register
	logic                           out_valid_q;
	logic [dtsw_pkg::COLOR_W-1:0]   out_color_q;
	logic [dtsw_pkg::DEPTH_W-1:0]   out_depth_q;
	logic [dtsw_pkg::COUNT_W-1:0]   out_count_q;

	dtsw_pkg::mem_req_t           mem_req;
	logic [dtsw_pkg::COLOR_W-1:0] mem_color;
	logic [dtsw_pkg::DEPTH_W-1:0] mem_depth;

	logic signed [12:0] y0_s, y1_s, lo_s, hi_s, eh_s, span_s;
	logic               x_in;
	logic               hit;
	logic [dtsw_pkg::DIM_W-1:0] mul_a;
	logic               accept, out_free;

	assign ew = (frame_width_q > dtsw_pkg::DIM_W'(dtsw_pkg::MAX_WIDTH))
		? dtsw_pkg::DIM_W'(dtsw_pkg::MAX_WIDTH) : frame_width_q;
	assign eh = (frame_height_q > dtsw_pkg::DIM_W'(dtsw_pkg::MAX_HEIGHT))
		? dtsw_pkg::DIM_W'(dtsw_pkg::MAX_HEIGHT) : frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= dtsw_pkg::DIM_W'(256);
			frame_height_q <= dtsw_pkg::DIM_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				dtsw_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				dtsw_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= dtsw_pkg::mode_t'(s_tuser);
			x_q     <= s_tdata[11:0];
			y0_q    <= s_tdata[23:12];
			y1_q    <= s_tdata[35:24];
			color_q <= s_tdata[59:36];
			depth_q <= s_tdata[91:60];
		end
	end

	// bounds: a point or read is a span of one row
	always_comb begin
		y0_s   = {y0_q[11], y0_q};
		y1_s   = (mode_q == dtsw_pkg::MODE_SPAN) ? {y1_q[11], y1_q} : y0_s + 13'sd1;
		eh_s   = {4'b0, eh};
		lo_s   = y0_s[12] ? 13'sd0 : y0_s;
		hi_s   = (y1_s > eh_s) ? eh_s : y1_s;
		span_s = hi_s - lo_s;
		x_in   = !x_q[11] && ({1'b0, x_q[10:0]} < {3'b0, ew});
		mul_a  = (mode_q == dtsw_pkg::MODE_CLEAR) ? eh : {1'b0, lo_q};
	end

	assign hit = valid_s1 && (mode_q != dtsw_pkg::MODE_READ) && (depth_q < mem_depth);

	always_comb begin
		mem_req.rd_addr = addr_q;
		if (state_q == ST_CLEAR) begin
			mem_req.wr_addr     = clr_cnt_q[dtsw_pkg::ADDR_W-1:0];
			mem_req.wr_color_en = clr_c_q;
			mem_req.wr_depth_en = clr_d_q;
			mem_req.wr_color    = '0;
			mem_req.wr_depth    = dtsw_pkg::FAR_DEPTH;
		end else begin
			mem_req.wr_addr     = addr_s1;
			mem_req.wr_color_en = hit;
			mem_req.wr_depth_en = hit;
			mem_req.wr_color    = color_q;
			mem_req.wr_depth    = depth_q;
		end
	end

	dtsw_plane_mem u_mem (
		.clk      (clk),
		.req      (mem_req),
		.rd_color (mem_color),
		.rd_depth (mem_depth)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			boot_q      <= 1'b1;
			clr_c_q     <= 1'b1;
			clr_d_q     <= 1'b1;
			clr_cnt_q   <= '0;
			clr_n_q     <= dtsw_pkg::CLR_CNT_W'(dtsw_pkg::STORE_SIZE);
			ok_q        <= 1'b0;
			lo_q        <= '0;
			rows_q      <= '0;
			prod_q      <= '0;
			addr_q      <= '0;
			valid_s1    <= 1'b0;
			addr_s1     <= '0;
			count_q     <= '0;
			rc_q        <= '0;
			rd_q        <= '0;
			out_valid_q <= 1'b0;
			out_color_q <= '0;
			out_depth_q <= '0;
			out_count_q <= '0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			// compare stage: read data lines up with addr_s1
			valid_s1 <= 1'b0;
			if (hit) begin
				count_q <= count_q + 1'b1;
			end
			if (valid_s1 && mode_q == dtsw_pkg::MODE_READ) begin
				rc_q <= mem_color;
				rd_q <= mem_depth;
			end
			if (accept) begin
				clr_c_q <= s_tdata[92];
				clr_d_q <= s_tdata[93];
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q + 1'b1 == clr_n_q) begin
						// the sweep after reset answers no beat
						boot_q  <= 1'b0;
						state_q <= boot_q ? ST_IDLE : ST_DONE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					ok_q    <= x_in && (lo_s < hi_s);
					lo_q    <= lo_s[7:0];
					rows_q  <= span_s[dtsw_pkg::DIM_W-1:0];
					count_q <= '0;
					rc_q    <= '0;
					rd_q    <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q  <= {{dtsw_pkg::DIM_W{1'b0}}, mul_a} * {{dtsw_pkg::DIM_W{1'b0}}, ew};
					state_q <= ST_LAUNCH;
				end
				ST_LAUNCH: begin
					if (mode_q == dtsw_pkg::MODE_CLEAR) begin
						clr_cnt_q <= '0;
						clr_n_q   <= prod_q[dtsw_pkg::CLR_CNT_W-1:0];
						state_q   <= (prod_q == '0) ? ST_DONE : ST_CLEAR;
					end else begin
						addr_q  <= prod_q[dtsw_pkg::ADDR_W-1:0] + {8'b0, x_q[7:0]};
						state_q <= ok_q ? ST_SPAN : ST_DONE;
					end
				end
				ST_SPAN: begin
					valid_s1 <= 1'b1;
					addr_s1  <= addr_q;
					addr_q   <= addr_q + {7'b0, ew};
					rows_q   <= rows_q - 1'b1;
					if (rows_q == dtsw_pkg::DIM_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_color_q <= rc_q;
						out_depth_q <= rd_q;
						out_count_q <= count_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_count_q, out_depth_q, out_color_q};

endmodule

`default_nettype wire

### rtl/dtsw_checker.sv
// dtsw_checker: port-level assertions for depth_tested_span_writer_core
// bound to the top level below; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

module dtsw_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [71:0] m_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready
);

	// a result beat stays offered until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("stalled result beat changed");

	// input closes right after a beat is taken, while the item is processed
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken on back-to-back cycles");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[64:56] <= 9'd256)
		else $error("pixel count above one column");

	// a write count and read-back data never come in the same beat
	a_write_or_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[64:56] != 9'd0 |-> m_tdata[55:0] == 56'd0)
		else $error("read data on a beat that wrote pixels");

endmodule

bind depth_tested_span_writer_core dtsw_checker u_dtsw_checker (.*);

`default_nettype wire
